>>> sv/edrle_pkg.sv
// Package for the ED-escape run-length decoder.
// Holds shared constants, the run descriptor type and the queue push type.
// No dependencies; the top level, core, result queue and checker import it.
package edrle_pkg;

    localparam logic [7:0]  ESC_BYTE      = 8'hED;
    localparam logic [15:0] MAX_CAPACITY  = 16'd49152;
    localparam logic [15:0] CAP_RESET_VAL = 16'd16384;

    // APB register map: one register per 32-bit word, index taken from paddr[2].
    localparam int unsigned APB_ADDR_W = 3;
    localparam logic        REG_OUTPUT_CAPACITY = 1'b0;

    // Result queue: two entries of headroom beyond the one being drained.
    localparam int unsigned Q_DEPTH  = 4;
    localparam int unsigned QPTR_W   = $clog2(Q_DEPTH);
    localparam int unsigned QCNT_W   = $clog2(Q_DEPTH + 1);
    localparam logic [QCNT_W-1:0] Q_READY_LIMIT = QCNT_W'(Q_DEPTH - 2);

    typedef struct packed {
        logic [7:0]  run_value;
        logic [7:0]  run_length;
        logic [15:0] write_offset;
        logic        buffer_full;
    } t_run;

    // Results produced by one accepted input item, in output order.
    typedef struct packed {
        logic [1:0] cnt;
        t_run       run0;
        t_run       run1;
    } t_push;

endpackage

>>> sv/edrle_if.sv
// Handshake interfaces for the ED-escape run-length decoder channels.
// The input channel carries compressed bytes, the output channel run descriptors.
// No dependencies.
interface edrle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_stream;

    modport source (output valid, output in_byte, output end_of_stream, input ready);
    modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface edrle_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  run_value;
    logic [7:0]  run_length;
    logic [15:0] write_offset;
    logic        buffer_full;

    modport source (output valid, output run_value, output run_length,
                    output write_offset, output buffer_full, input ready);
    modport sink   (input valid, input run_value, input run_length,
                    input write_offset, input buffer_full, output ready);
endinterface

>>> sv/ed_escape_rle_decoder.sv
// ED-escape run-length decoder, top level: APB register, decode core, result queue.
// A run descriptor is registered into the result queue when its byte is accepted.
// Throughput: one byte per cycle while input ready is high; a byte yielding two runs queues both.
// Input ready drops when the four-entry result queue has fewer than two free entries.
// Reset (synchronous, active low) empties the queue, sets the decoder idle at offset 0
// and output_capacity to 16384.
module ed_escape_rle_decoder import edrle_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    edrle_in_if.sink              i_in,
    edrle_out_if.source           o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [15:0] r_capacity;
    logic        take;
    t_push       push;
    t_run        run;
    logic        room;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_OUTPUT_CAPACITY) ? {16'd0, r_capacity} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET_VAL;
        end else if (psel && penable && pwrite && (paddr[2] == REG_OUTPUT_CAPACITY)) begin
            r_capacity <= pwdata[15:0];
        end
    end

    assign i_in.ready = room;
    assign take       = i_in.valid && room;

    edrle_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_capacity (r_capacity),
        .i_take     (take),
        .i_in_byte  (i_in.in_byte),
        .i_eos      (i_in.end_of_stream),
        .o_push     (push)
    );

    edrle_result_q u_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_out.ready),
        .o_room  (room),
        .o_valid (o_out.valid),
        .o_run   (run)
    );

    assign o_out.run_value    = run.run_value;
    assign o_out.run_length   = run.run_length;
    assign o_out.write_offset = run.write_offset;
    assign o_out.buffer_full  = run.buffer_full;

endmodule

>>> sv/edrle_core.sv
// Decoder state and per-byte decode logic of the ED-escape run-length decoder.
// Produces zero, one or two run descriptors per accepted byte.
// Depends on edrle_pkg.
module edrle_core import edrle_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_capacity,
    input  logic        i_take,
    input  logic [7:0]  i_in_byte,
    input  logic        i_eos,
    output t_push       o_push
);

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_SEEN_ED    = 3'd1,
        PH_WANT_COUNT = 3'd2,
        PH_WANT_VALUE = 3'd3,
        PH_FULL       = 3'd4
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_count, n_count;
    logic [15:0] r_wp, n_wp;

    always_comb begin
        logic [15:0] cap;
        logic [15:0] rem;
        logic        full_now;
        logic        emit1;
        logic        emit2;
        logic        emit2_ok;
        logic [7:0]  v1;
        logic [7:0]  req1;
        logic [7:0]  len1;
        logic [15:0] wp1;
        logic [15:0] wp2;
        logic        full1;
        logic        full2;

        cap      = (i_capacity > MAX_CAPACITY) ? MAX_CAPACITY : i_capacity;
        full_now = (r_wp >= cap) || (r_phase == PH_FULL);
        rem      = cap - r_wp;

        n_phase = r_phase;
        n_count = r_count;
        n_wp    = r_wp;
        emit1   = 1'b0;
        emit2   = 1'b0;
        v1      = i_in_byte;
        req1    = 8'd1;

        if (full_now) begin
            n_phase = PH_FULL;
        end else begin
            case (r_phase)
                PH_SEEN_ED: begin
                    if (i_in_byte == ESC_BYTE) begin
                        n_phase = PH_WANT_COUNT;
                    end else begin
                        // The held ED goes out as a literal, then this byte if the buffer is not yet full.
                        n_phase = PH_IDLE;
                        emit1   = 1'b1;
                        v1      = ESC_BYTE;
                        emit2   = 1'b1;
                    end
                end
                PH_WANT_COUNT: begin
                    n_count = i_in_byte;
                    n_phase = PH_WANT_VALUE;
                end
                PH_WANT_VALUE: begin
                    n_phase = PH_IDLE;
                    n_count = 8'd0;
                    if (r_count != 8'd0) begin
                        emit1 = 1'b1;
                        req1  = r_count;
                    end
                end
                default: begin
                    if (i_in_byte == ESC_BYTE) begin
                        n_phase = PH_SEEN_ED;
                    end else begin
                        n_phase = PH_IDLE;
                        emit1   = 1'b1;
                    end
                end
            endcase
        end

        // A lone ED held at end of stream is flushed as a literal.
        if (i_eos && (n_phase == PH_SEEN_ED)) begin
            emit1 = 1'b1;
            v1    = ESC_BYTE;
        end

        len1     = ({8'd0, req1} < rem) ? req1 : rem[7:0];
        wp1      = r_wp + {8'd0, len1};
        full1    = (wp1 >= cap);
        emit2_ok = emit2 && !full1;
        wp2      = wp1 + 16'd1;
        full2    = (wp2 >= cap);

        if (emit1) begin
            n_wp = wp1;
            if (full1) begin
                n_phase = PH_FULL;
            end
        end
        if (emit2_ok) begin
            n_wp = wp2;
            if (full2) begin
                n_phase = PH_FULL;
            end
        end

        if (i_eos) begin
            n_phase = PH_IDLE;
            n_count = 8'd0;
            n_wp    = 16'd0;
        end

        o_push.run0.run_value    = v1;
        o_push.run0.run_length   = len1;
        o_push.run0.write_offset = r_wp;
        o_push.run0.buffer_full  = full1;
        o_push.run1.run_value    = i_in_byte;
        o_push.run1.run_length   = 8'd1;
        o_push.run1.write_offset = wp1;
        o_push.run1.buffer_full  = full2;
        if (!i_take || !emit1) begin
            o_push.cnt = 2'd0;
        end else if (emit2_ok) begin
            o_push.cnt = 2'd2;
        end else begin
            o_push.cnt = 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= 8'd0;
            r_wp    <= 16'd0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_wp    <= n_wp;
        end
    end

endmodule

>>> sv/edrle_result_q.sv
// Small result queue of the ED-escape run-length decoder.
// Takes up to two run descriptors per cycle and hands out one per transaction.
// Depends on edrle_pkg.
module edrle_result_q import edrle_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_pop,
    output logic  o_room,
    output logic  o_valid,
    output t_run  o_run
);

    t_run              r_mem [Q_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              pop_ok;
    logic [QPTR_W-1:0] wr_ptr_p1;

    assign pop_ok    = i_pop && (r_cnt != '0);
    assign o_valid   = (r_cnt != '0);
    assign o_run     = r_mem[r_rd_ptr];
    assign o_room    = (r_cnt <= Q_READY_LIMIT);
    assign wr_ptr_p1 = r_wr_ptr + QPTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.run0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_ptr_p1] <= i_push.run1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QPTR_W'(i_push.cnt);
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_cnt <= r_cnt + QCNT_W'(i_push.cnt) - QCNT_W'(pop_ok);
        end
    end

endmodule

>>> sv/edrle_checker.sv
// Port-level checks for the ED-escape run-length decoder, bound to the top level.
// Sees only the top-level ports. Depends on edrle_pkg.
module edrle_checker import edrle_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [7:0]            i_run_length,
    input logic [15:0]           i_write_offset,
    input logic                  i_buffer_full,
    input logic                  i_psel,
    input logic                  i_penable,
    input logic                  i_pwrite,
    input logic [APB_ADDR_W-1:0] i_paddr,
    input logic [31:0]           i_pwdata,
    input logic [31:0]           i_prdata
);

    // A stalled result transaction keeps its write offset, run length and buffer-full flag.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_write_offset)
            && $stable(i_run_length) && $stable(i_buffer_full))
        else $error("result changed while stalled");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_run_length != 8'd0)
        else $error("run of zero length");

    a_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ({1'b0, i_write_offset} + {9'd0, i_run_length})
            <= {1'b0, MAX_CAPACITY})
        else $error("run extends beyond maximum capacity");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_psel && i_penable && i_pwrite && (i_paddr[2] == REG_OUTPUT_CAPACITY)
            |=> i_prdata[15:0] == $past(i_pwdata[15:0]) || !i_paddr[2] == 1'b0)
        else $error("capacity register did not take the written value");

endmodule

bind ed_escape_rle_decoder edrle_checker u_edrle_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_run_length   (o_out.run_length),
    .i_write_offset (o_out.write_offset),
    .i_buffer_full  (o_out.buffer_full),
    .i_psel         (psel),
    .i_penable      (penable),
    .i_pwrite       (pwrite),
    .i_paddr        (paddr),
    .i_pwdata       (pwdata),
    .i_prdata       (prdata)
);
